// ===== sv/driver_alert_state_machine_core_defines.svh =====
// ----------------------------------------------------------------------------
// Driver alert state machine: assertion macros
// Concurrent assertion wrappers on clk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef DRIVER_ALERT_STATE_MACHINE_CORE_DEFINES_SVH
`define DRIVER_ALERT_STATE_MACHINE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define DASM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define DASM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DASM_ASSERT(lbl, prop, msg)
`define DASM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/dasm_pkg.sv =====
// ----------------------------------------------------------------------------
// dasm_pkg
// Types, codes and the transition table of the driver alert state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package dasm_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned EVENT_W   = 4;
  localparam int unsigned CFG_IDX_W = 4;

  // alert states
  typedef enum logic [2:0] {
    ST_INIT   = 3'd0,
    ST_DETECT = 3'd1,
    ST_LIGHT  = 3'd2,
    ST_STRONG = 3'd3,
    ST_PHONE  = 3'd4,
    ST_FAULT  = 3'd5
  } mode_state_t;

  // event codes; codes above unknown are unlisted
  typedef enum logic [EVENT_W-1:0] {
    EV_CONT     = 4'd0,
    EV_FILLER   = 4'd1,
    EV_ONE_HAND = 4'd2,
    EV_MILD     = 4'd3,
    EV_HARSH    = 4'd4,
    EV_NO_HANDS = 4'd5,
    EV_PHONE    = 4'd6,
    EV_EXPIRED  = 4'd7,
    EV_UNKNOWN  = 4'd8
  } event_code_t;

  // operations
  typedef enum logic {
    OP_EVENT   = 1'b0,
    OP_RESTART = 1'b1
  } operation_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_TO  = 4'd0,
    CFG_STRONG_TO = 4'd1,
    CFG_PHONE_TO  = 4'd2,
    CFG_ERROR_TO  = 4'd3
  } cfg_idx_t;

  typedef struct packed {
    logic               operation;
    logic [EVENT_W-1:0] event_code;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        current_state;
    logic [TIME_W-1:0] entered_at_ms;
  } out_item_t;

  // timeout settings, zero disables
  typedef struct packed {
    logic [TIME_W-1:0] light_ms;
    logic [TIME_W-1:0] strong_ms;
    logic [TIME_W-1:0] phone_ms;
    logic [TIME_W-1:0] error_ms;
  } timeout_cfg_t;

  // next state and entry time of one step
  typedef struct packed {
    mode_state_t       state;
    logic [TIME_W-1:0] entry_ms;
  } step_res_t;

  // transition table; pairs not listed keep the state
  function automatic mode_state_t next_state(mode_state_t st, logic [EVENT_W-1:0] ev);
    mode_state_t nxt;
    nxt = st;
    case (ev)
      EV_PHONE:   nxt = ST_PHONE;
      EV_UNKNOWN: nxt = ST_FAULT;
      EV_EXPIRED: begin
        if (st != ST_INIT) begin
          nxt = ST_DETECT;
        end
      end
      EV_CONT: begin
        if (st == ST_INIT || st == ST_FAULT) begin
          nxt = ST_DETECT;
        end
      end
      EV_ONE_HAND, EV_MILD: begin
        if (st == ST_DETECT) begin
          nxt = ST_LIGHT;
        end
      end
      EV_HARSH, EV_NO_HANDS: begin
        if (st == ST_DETECT || st == ST_LIGHT) begin
          nxt = ST_STRONG;
        end
      end
      default: nxt = st;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ===== sv/driver_alert_state_machine_core.sv =====
// ----------------------------------------------------------------------------
// driver_alert_state_machine_core
// Driver alert state machine with configurable timeouts per state.
//
//   port group   dir   handshake            content
//   in_*         in    in_valid / in_stall  operation, event code, time
//   out_*        out   out_valid/out_stall  current state, entry time
//   cfg_*        in    cfg_valid/cfg_ready  register index, timeout value
//
// One item per cycle sustained while out_stall is low; an accepted beat
// moves from the input register into the result register, where it is valid.
// The state and entry time update as an item moves from the input register
// into the result register, so the next item sees them in the following cycle.
// Synchronous active-low reset clears state to init, entry time and timeouts.
// A stalled result holds; the input register keeps taking beats while the
// result register is free or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

`include "driver_alert_state_machine_core_defines.svh"

module driver_alert_state_machine_core import dasm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data
);

  timeout_cfg_t      timeouts;
  logic              held_valid;
  in_item_t          held_item;
  logic              fire;
  step_res_t         step;
  mode_state_t       state_r;
  logic [TIME_W-1:0] entry_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_data_r;

  dasm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timeouts  (timeouts)
  );

  dasm_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  dasm_next u_next (
    .state    (state_r),
    .entry_ms (entry_r),
    .item     (held_item),
    .timeouts (timeouts),
    .res      (step)
  );

  // advance when the result register is empty or draining
  assign fire = held_valid && (!out_valid_r || !out_stall);

  // machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      entry_r <= '0;
    end else if (fire) begin
      state_r <= step.state;
      entry_r <= step.entry_ms;
    end
  end

  // result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.current_state <= step.state;
      out_data_r.entered_at_ms <= step.entry_ms;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a restart lands in init stamped with its own time
  `DASM_ASSERT(a_restart_init, fire && held_item.operation == OP_RESTART |=> state_r == ST_INIT && entry_r == $past(held_item.now_ms), "restart did not reach init")
  // the entry time moves only with a state change or a restart
  `DASM_ASSERT(a_entry_hold, fire && held_item.operation == OP_EVENT && step.state == state_r |=> $stable(entry_r), "entry time moved without a state change")
  // an unknown event always ends in error
  `DASM_ASSERT(a_unknown_err, fire && held_item.operation == OP_EVENT && held_item.event_code == EV_UNKNOWN |=> state_r == ST_FAULT, "unknown event missed error")
  // never overwrite a held result
  `DASM_ASSERT(a_no_overwrite, out_valid_r && out_stall |-> !fire, "result overwritten while stalled")
  // the result register tracks the machine state
  `DASM_ASSERT(a_out_match, out_valid_r && $past(fire) |-> out_data_r.current_state == state_r, "result and state disagree")

endmodule

`default_nettype wire

// ===== sv/dasm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dasm_cfg_regs
// Timeout configuration registers, written through the cfg channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dasm_cfg_regs import dasm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data,
  output timeout_cfg_t              timeouts
);

  timeout_cfg_t cfg_r;

  // always able to take a write beat
  assign cfg_ready = 1'b1;
  assign timeouts  = cfg_r;

  // decode index and load the register; unused indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LIGHT_TO:  cfg_r.light_ms  <= cfg_data;
        CFG_STRONG_TO: cfg_r.strong_ms <= cfg_data;
        CFG_PHONE_TO:  cfg_r.phone_ms  <= cfg_data;
        CFG_ERROR_TO:  cfg_r.error_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/dasm_in_stage.sv =====
// ----------------------------------------------------------------------------
// dasm_in_stage
// Input register: captures one beat and holds it until the step consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dasm_in_stage import dasm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  in_item_t      in_data,
  input  wire logic     advance,
  output logic          held_valid,
  output in_item_t      held_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  // stall only while a held beat cannot move on
  assign in_stall   = valid_r && !advance;
  assign load       = in_valid && !in_stall;
  assign held_valid = valid_r;
  assign held_item  = item_r;

  // occupancy of the register
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dasm_next.sv =====
// ----------------------------------------------------------------------------
// dasm_next
// One step of the alert machine: timeout check, event override and lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module dasm_next import dasm_pkg::*; (
  input  mode_state_t             state,
  input  wire logic [TIME_W-1:0]  entry_ms,
  input  in_item_t                item,
  input  timeout_cfg_t            timeouts,
  output step_res_t               res
);

  logic [TIME_W-1:0]  limit;
  logic [TIME_W-1:0]  elapsed;
  logic               expired;
  logic [EVENT_W-1:0] ev;
  mode_state_t        st_nxt;

  // pick the timeout of the current state
  always_comb begin
    case (state)
      ST_LIGHT:  limit = timeouts.light_ms;
      ST_STRONG: limit = timeouts.strong_ms;
      ST_PHONE:  limit = timeouts.phone_ms;
      ST_FAULT:  limit = timeouts.error_ms;
      default:   limit = '0;
    endcase
  end

  // wrapping time in state against the limit
  assign elapsed = item.now_ms - entry_ms;
  assign expired = (limit != '0) && (elapsed >= limit);

  // timeout overrides all but phone and unknown
  always_comb begin
    ev = item.event_code;
    if (expired && item.event_code != EV_PHONE && item.event_code != EV_UNKNOWN) begin
      ev = EV_EXPIRED;
    end
  end

  // next state
  always_comb begin
    if (item.operation == OP_RESTART) begin
      st_nxt = ST_INIT;
    end else begin
      st_nxt = next_state(state, ev);
    end
  end

  // outputs: state and entry time, reloaded on a change or a restart
  always_comb begin
    res.state    = st_nxt;
    res.entry_ms = entry_ms;
    if (item.operation == OP_RESTART || st_nxt != state) begin
      res.entry_ms = item.now_ms;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_driver_alert_state_machine_core.sv =====
// ----------------------------------------------------------------------------
// tb_driver_alert_state_machine_core
// Self-checking bench for the driver alert state machine. A directed plan
// walks every state, event, restart, wrap-around time and timeout extreme,
// then random event streams run under several sender and receiver paces.
// Each result beat is checked against a row's want or the in-bench model.
// ----------------------------------------------------------------------------
module tb_driver_alert_state_machine_core import dasm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 110;
  localparam int PLAN_ROWS    = 34;

  // event codes past unknown carry no meaning of their own
  localparam logic [EVENT_W-1:0] EV_UNLISTED_LO = 4'd9;
  localparam logic [EVENT_W-1:0] EV_UNLISTED_HI = 4'd15;

  // next state by [state][event code], one row per state
  localparam int ALERT_NEXT [6][16] = '{
    '{1, 0, 0, 0, 0, 0, 4, 0, 5, 0, 0, 0, 0, 0, 0, 0},  // init
    '{1, 1, 2, 2, 3, 3, 4, 1, 5, 1, 1, 1, 1, 1, 1, 1},  // detecting
    '{2, 2, 2, 2, 3, 3, 4, 1, 5, 2, 2, 2, 2, 2, 2, 2},  // light alert
    '{3, 3, 3, 3, 3, 3, 4, 1, 5, 3, 3, 3, 3, 3, 3, 3},  // strong alert
    '{4, 4, 4, 4, 4, 4, 4, 1, 5, 4, 4, 4, 4, 4, 4, 4},  // phone alarm
    '{1, 5, 5, 5, 5, 5, 4, 1, 5, 5, 5, 5, 5, 5, 5, 5}   // error
  };

  typedef enum {SINK_OPEN, SINK_SPARSE, SINK_LIGHT, SINK_HOLD} sink_pace_t;

  typedef struct packed {
    logic        is_cfg;
    cfg_idx_t    reg_idx;
    logic [31:0] reg_val;
    in_item_t    item;
    logic        typed;
    out_item_t   want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0] cfg_data = '0;

  // typed expectation riding along with the input beat
  logic      in_chk = 1'b0;
  out_item_t in_want = '0;

  // model of the machine
  mode_state_t       trk_state;
  logic [TIME_W-1:0] trk_entry;
  timeout_cfg_t      tmo;

  out_item_t  expected_alerts [$];
  out_item_t  seen_want;
  out_item_t  seen_pred;
  int         alert_errors = 0;
  int         quiet_cycles = 0;
  int         hold_cnt = 0;
  int         src_gap_pct = 0;
  sink_pace_t sink_pace = SINK_OPEN;
  plan_row_t  directed_plan [PLAN_ROWS];

  driver_alert_state_machine_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // advance the model by one item and return the state it reports
  function automatic out_item_t alert_step(input in_item_t it);
    mode_state_t       st;
    mode_state_t       nxt;
    logic [EVENT_W-1:0] ev;
    logic [TIME_W-1:0] lim;
    out_item_t         res;
    if (it.operation == OP_RESTART) begin
      trk_state = ST_INIT;
      trk_entry = it.now_ms;
    end else begin
      st = trk_state;
      ev = it.event_code;
      case (st)
        ST_LIGHT:  lim = tmo.light_ms;
        ST_STRONG: lim = tmo.strong_ms;
        ST_PHONE:  lim = tmo.phone_ms;
        ST_FAULT:  lim = tmo.error_ms;
        default:   lim = '0;
      endcase
      // an elapsed timeout overrides all but phone and unknown
      if (lim != '0 && (it.now_ms - trk_entry) >= lim &&
          ev != EV_PHONE && ev != EV_UNKNOWN) begin
        ev = EV_EXPIRED;
      end
      nxt = mode_state_t'(ALERT_NEXT[st][ev][2:0]);
      if (nxt != st) begin
        trk_entry = it.now_ms;
      end
      trk_state = nxt;
    end
    res.current_state = trk_state;
    res.entered_at_ms = trk_entry;
    return res;
  endfunction

  function automatic plan_row_t event_row(input operation_t op, input logic [EVENT_W-1:0] ev,
                                          input logic [TIME_W-1:0] now);
    plan_row_t r;
    r = '0;
    r.item.operation  = op;
    r.item.event_code = ev;
    r.item.now_ms     = now;
    return r;
  endfunction

  function automatic plan_row_t checked_row(input operation_t op, input logic [EVENT_W-1:0] ev,
                                            input logic [TIME_W-1:0] now,
                                            input mode_state_t st, input logic [TIME_W-1:0] at);
    plan_row_t r;
    r = event_row(op, ev, now);
    r.typed = 1'b1;
    r.want.current_state = st;
    r.want.entered_at_ms = at;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_idx_t idx, input logic [TIME_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] pick_timeout();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      default: return $urandom_range(2, 80);
    endcase
  endfunction

  // offer one beat, idling first as the sender pace asks; return on acceptance
  task automatic send_event(input in_item_t it, input logic typed, input out_item_t want);
    while (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    in_chk   <= typed;
    in_want  <= want;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // drop valid and wait until the pipeline has nothing left in flight
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_alerts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one write beat, then valid low again before returning
  task automatic write_timeout(input cfg_idx_t idx, input logic [TIME_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver pace; the hold pattern stalls in bursts set by hold_cnt
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      case (sink_pace)
        SINK_SPARSE: out_stall <= ($urandom_range(0, 99) < 86);
        SINK_LIGHT:  out_stall <= ($urandom_range(0, 99) < 7);
        SINK_HOLD: begin
          hold_cnt = (hold_cnt + 1) % 80;
          out_stall <= (hold_cnt < 60);
        end
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // track config, predict on input beats, check result beats
  always @(posedge clk) begin
    if (!rst_n) begin
      trk_state = ST_INIT;
      trk_entry = '0;
      tmo = '0;
      expected_alerts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_alerts.size() == 0) begin
          $error("unexpected result beat: current_state %0d entered_at_ms 0x%08h",
                 out_data.current_state, out_data.entered_at_ms);
          alert_errors++;
        end else begin
          seen_want = expected_alerts.pop_front();
          if (out_data.current_state !== seen_want.current_state) begin
            $error("current_state: expected %0d, actual %0d",
                   seen_want.current_state, out_data.current_state);
            alert_errors++;
          end
          if (out_data.entered_at_ms !== seen_want.entered_at_ms) begin
            $error("entered_at_ms: expected 0x%08h, actual 0x%08h",
                   seen_want.entered_at_ms, out_data.entered_at_ms);
            alert_errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LIGHT_TO:  tmo.light_ms  = cfg_data;
          CFG_STRONG_TO: tmo.strong_ms = cfg_data;
          CFG_PHONE_TO:  tmo.phone_ms  = cfg_data;
          CFG_ERROR_TO:  tmo.error_ms  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        seen_pred = alert_step(in_data);
        expected_alerts.push_back(in_chk ? in_want : seen_pred);
      end
    end
  end

  // end the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("driver_alert_state_machine_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    in_item_t          it;
    logic [TIME_W-1:0] stamp_ms;
    int                r;

    directed_plan = '{
      // timeouts disabled: walk the table
      checked_row(OP_EVENT, EV_FILLER, 32'd0, ST_INIT, 32'd0),
      event_row(OP_EVENT, EV_CONT, 32'd5),
      event_row(OP_EVENT, EV_ONE_HAND, 32'd10),
      event_row(OP_EVENT, EV_HARSH, 32'd20),
      event_row(OP_EVENT, EV_EXPIRED, 32'd30),
      event_row(OP_EVENT, EV_MILD, 32'd40),
      event_row(OP_EVENT, EV_NO_HANDS, 32'd50),
      event_row(OP_EVENT, EV_PHONE, 32'd60),
      event_row(OP_EVENT, EV_UNLISTED_LO, 32'd70),
      event_row(OP_EVENT, EV_CONT, 32'd80),
      checked_row(OP_EVENT, EV_UNKNOWN, 32'd90, ST_FAULT, 32'd90),
      event_row(OP_EVENT, EV_CONT, 32'd100),
      checked_row(OP_RESTART, EV_UNLISTED_HI, 32'hFFFF_FFFF, ST_INIT, 32'hFFFF_FFFF),
      checked_row(OP_EVENT, EV_UNKNOWN, 32'd0, ST_FAULT, 32'd0),
      // shortest timeouts
      cfg_row(CFG_LIGHT_TO, 32'd1),
      cfg_row(CFG_STRONG_TO, 32'd1),
      cfg_row(CFG_PHONE_TO, 32'd1),
      cfg_row(CFG_ERROR_TO, 32'd1),
      checked_row(OP_RESTART, EV_CONT, 32'd1000, ST_INIT, 32'd1000),
      event_row(OP_EVENT, EV_CONT, 32'd1000),
      event_row(OP_EVENT, EV_ONE_HAND, 32'd1000),
      event_row(OP_EVENT, EV_HARSH, 32'd1001),
      event_row(OP_EVENT, EV_MILD, 32'd1001),
      event_row(OP_EVENT, EV_PHONE, 32'd5000),
      event_row(OP_EVENT, EV_UNKNOWN, 32'd6000),
      event_row(OP_EVENT, EV_UNLISTED_HI, 32'd5999),
      // longest timeouts, reached only by time running backwards
      cfg_row(CFG_LIGHT_TO, 32'hFFFF_FFFF),
      cfg_row(CFG_STRONG_TO, 32'hFFFF_FFFF),
      cfg_row(CFG_PHONE_TO, 32'hFFFF_FFFF),
      cfg_row(CFG_ERROR_TO, 32'hFFFF_FFFF),
      event_row(OP_EVENT, EV_UNKNOWN, 32'd10),
      event_row(OP_EVENT, EV_FILLER, 32'd9),
      event_row(OP_EVENT, EV_NO_HANDS, 32'd20),
      event_row(OP_EVENT, EV_FILLER, 32'd19)
    };

    // hold reset, then release
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed plan
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        settle_idle();
        write_timeout(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        send_event(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // random streams, one pace per phase
    for (int p = 0; p < 5; p++) begin
      settle_idle();
      case (p)
        1:       begin src_gap_pct = 86; sink_pace = SINK_OPEN;   end
        2:       begin src_gap_pct = 0;  sink_pace = SINK_SPARSE; end
        3:       begin src_gap_pct = 7;  sink_pace = SINK_LIGHT;  end
        4:       begin src_gap_pct = 0;  sink_pace = SINK_HOLD;   end
        default: begin src_gap_pct = 0;  sink_pace = SINK_OPEN;   end
      endcase
      write_timeout(CFG_LIGHT_TO, pick_timeout());
      write_timeout(CFG_STRONG_TO, pick_timeout());
      write_timeout(CFG_PHONE_TO, pick_timeout());
      write_timeout(CFG_ERROR_TO, pick_timeout());
      stamp_ms = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly small time steps so timeouts land near their limits
        r = $urandom_range(0, 99);
        if (r < 85) begin
          stamp_ms += $urandom_range(0, 30);
        end else if (r < 95) begin
          stamp_ms += $urandom_range(31, 300);
        end else if (r < 98) begin
          stamp_ms = $urandom;
        end else begin
          stamp_ms -= $urandom_range(1, 60);
        end
        r = $urandom_range(0, 99);
        if (r < 84) begin
          it.event_code = EVENT_W'($urandom_range(EV_CONT, EV_EXPIRED));
        end else if (r < 92) begin
          it.event_code = EV_UNKNOWN;
        end else begin
          it.event_code = EVENT_W'($urandom_range(EV_UNLISTED_LO, EV_UNLISTED_HI));
        end
        it.operation = ($urandom_range(0, 99) < 4) ? OP_RESTART : OP_EVENT;
        it.now_ms    = stamp_ms;
        send_event(it, 1'b0, '0);
      end
    end

    // drain with the receiver open
    src_gap_pct = 0;
    sink_pace   = SINK_OPEN;
    settle_idle();

    if (alert_errors == 0) begin
      $display("driver_alert_state_machine_core regression: pass");
    end else begin
      $display("driver_alert_state_machine_core regression: fail");
    end
    $finish;
  end

endmodule
